### rtl/core/bht_pkg.sv
// bht_pkg: sizes, codes and shared types of the bucketed hash table
// used by every module under rtl/core but bht_ram, no dependencies
package bht_pkg;

    localparam int NUM_BUCKETS  = 10;
    localparam int BUCKET_DEPTH = 8;
    localparam int KEY_BITS     = 16;

    // port field widths
    localparam int KEY_FIELD_W  = 16;
    localparam int STATUS_W     = 2;
    localparam int BUCKET_W     = 4;
    localparam int COUNT_W      = 7;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 16;

    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int CNT_W  = $clog2(NUM_BUCKETS * BUCKET_DEPTH + 1);
    localparam int ROW_W  = BUCKET_DEPTH * KEY_BITS;

    // key / NUM_BUCKETS as (key * RECIP) >> MOD_SHIFT, exact for KEY_BITS-bit keys
    localparam int MOD_SHIFT = KEY_BITS + IDX_W;
    localparam int RECIP_W   = KEY_BITS + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << MOD_SHIFT) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef logic [BUCKET_DEPTH-1:0][KEY_BITS-1:0] t_row;

    // outcome of one row update
    typedef struct packed {
        logic              wr;
        logic              inc;
        logic              dec;
        t_status           status;
        logic [FILL_W-1:0] fill;
    } t_upd;

endpackage

### rtl/core/bht_ram.sv
// bht_ram: generic single-port ram, one write or read per cycle, registered read
// no dependencies
module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bht_hash.sv
// bht_hash: bucket index as key modulo bucket count, reciprocal multiply then correction
// depends on bht_pkg
module bht_hash (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [bht_pkg::KEY_BITS-1:0]   i_key,
    output logic [bht_pkg::KEY_BITS-1:0]   o_key,
    output logic [bht_pkg::IDX_W-1:0]      o_bucket
);

    localparam int PROD_W = bht_pkg::KEY_BITS + bht_pkg::RECIP_W;

    logic [bht_pkg::KEY_BITS-1:0] r_key;
    logic [bht_pkg::KEY_BITS-1:0] r_quot;
    logic [PROD_W-1:0]            prod;
    logic [bht_pkg::KEY_BITS-1:0] rem;

    assign prod = PROD_W'(i_key) * PROD_W'(bht_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key  <= i_key;
            r_quot <= bht_pkg::KEY_BITS'(prod >> bht_pkg::MOD_SHIFT);
        end
    end

    // remainder fits the low bits, wraparound of the subtract is harmless
    assign rem      = r_key - bht_pkg::KEY_BITS'(r_quot * bht_pkg::NUM_BUCKETS);
    assign o_bucket = bht_pkg::IDX_W'(rem);
    assign o_key    = r_key;

endmodule

### rtl/core/bht_row.sv
// bht_row: search, shift and rebuild of one bucket row for insert or delete
// depends on bht_pkg
module bht_row (
    input  bht_pkg::t_op                  i_mode,
    input  logic [bht_pkg::KEY_BITS-1:0]  i_key,
    input  logic [bht_pkg::FILL_W-1:0]    i_fill,
    input  bht_pkg::t_row                 i_row,
    output bht_pkg::t_row                 o_row,
    output bht_pkg::t_upd                 o_upd
);

    localparam logic [bht_pkg::FILL_W-1:0] DEPTH_F = bht_pkg::FILL_W'(bht_pkg::BUCKET_DEPTH);

    logic [bht_pkg::FILL_W-1:0]   fill;
    logic [bht_pkg::ROW_W-1:0]    flat;
    bht_pkg::t_row                row_up;
    bht_pkg::t_row                row_dn;
    logic [bht_pkg::BUCKET_DEPTH-1:0] match;
    logic                         found;
    logic [bht_pkg::FILL_W-1:0]   pos;

    assign fill   = (i_fill > DEPTH_F) ? DEPTH_F : i_fill;
    assign flat   = i_row;
    assign row_up = (flat << bht_pkg::KEY_BITS) | bht_pkg::ROW_W'(i_key);
    assign row_dn = flat >> bht_pkg::KEY_BITS;

    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < bht_pkg::BUCKET_DEPTH; i++) begin
            match[i] = (bht_pkg::FILL_W'(i) < fill) && (i_row[i] == i_key);
            // first hit from the head
            if (match[i] && !found) begin
                found = 1'b1;
                pos   = bht_pkg::FILL_W'(i);
            end
        end
    end

    always_comb begin
        o_row      = i_row;
        o_upd.wr   = 1'b0;
        o_upd.inc  = 1'b0;
        o_upd.dec  = 1'b0;
        o_upd.fill = fill;
        if (i_mode == bht_pkg::OP_INSERT) begin
            if (fill >= DEPTH_F) begin
                o_upd.status = bht_pkg::ST_FULL;
            end else begin
                o_upd.status = bht_pkg::ST_INSERTED;
                o_row        = row_up;
                o_upd.wr     = 1'b1;
                o_upd.inc    = 1'b1;
                o_upd.fill   = fill + 1'b1;
            end
        end else begin
            if (!found) begin
                o_upd.status = bht_pkg::ST_NOT_FOUND;
            end else begin
                o_upd.status = bht_pkg::ST_DELETED;
                for (int i = 0; i < bht_pkg::BUCKET_DEPTH; i++) begin
                    if (bht_pkg::FILL_W'(i) >= pos) begin
                        o_row[i] = row_dn[i];
                    end
                end
                o_upd.wr   = 1'b1;
                o_upd.dec  = 1'b1;
                o_upd.fill = fill - 1'b1;
            end
        end
    end

endmodule

### rtl/core/bucketed_hash_table.sv
// bucketed_hash_table: top level, sequencer, fill counters and result register
// depends on bht_pkg, bht_hash, bht_row, bht_ram
//
// Stores keys in buckets chosen by key modulo the bucket count, newest key at
// the head of each bucket, up to a fixed depth per bucket.
// Input channel s_axis: one word per operation, tuser selects insert or delete,
// tdata carries the key. Output channel m_axis: one word per operation with the
// status in tuser and the bucket index and total stored keys in tdata.
// Each word passes through the states idle, hash and update: accept and reciprocal
// multiply, bucket index and row read from the bucket ram, then compare, shift
// and write back of the row. A word that can load its result frees the input for
// the next cycle; no new word is taken before the last one is through.
// Results sit in an output register; if the receiver stalls while a result is
// pending, the following word waits in its update step and no new word is
// accepted until the result can be loaded.
// Reset empties every bucket and clears the key count at once; the ram itself
// is not cleared, only entries below a bucket's fill are ever read.
module bucketed_hash_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bht_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // key[15:0]
    input  logic                            s_axis_tuser,   // mode[0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bht_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // bucket_index[3:0], entry_count[10:4]
    output logic [bht_pkg::STATUS_W-1:0]    m_axis_tuser    // status[1:0]
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HASH = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic                         accept;
    logic                         commit;
    logic [bht_pkg::KEY_BITS-1:0] op_key;
    logic [bht_pkg::IDX_W-1:0]    hash_bucket;
    bht_pkg::t_op                 r_mode;
    logic [bht_pkg::IDX_W-1:0]    r_bucket;
    logic [bht_pkg::FILL_W-1:0]   r_fill [bht_pkg::NUM_BUCKETS];
    logic [bht_pkg::CNT_W-1:0]    r_total, n_total;
    logic [bht_pkg::IDX_W-1:0]    ram_addr;
    logic [bht_pkg::ROW_W-1:0]    ram_rdata;
    bht_pkg::t_row                new_row;
    bht_pkg::t_upd                upd;

    logic                         r_out_valid;
    bht_pkg::t_status             r_out_status;
    logic [bht_pkg::BUCKET_W-1:0] r_out_bucket;
    logic [bht_pkg::COUNT_W-1:0]  r_out_count;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);

    bht_hash u_hash (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_key    (bht_pkg::KEY_BITS'(s_axis_tdata[bht_pkg::KEY_FIELD_W-1:0])),
        .o_key    (op_key),
        .o_bucket (hash_bucket)
    );

    assign ram_addr = (r_state == S_HASH) ? hash_bucket : r_bucket;

    bht_ram #(
        .WIDTH (bht_pkg::ROW_W),
        .DEPTH (bht_pkg::NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (commit && upd.wr),
        .i_addr  (ram_addr),
        .i_wdata (new_row),
        .o_rdata (ram_rdata)
    );

    bht_row u_row (
        .i_mode (r_mode),
        .i_key  (op_key),
        .i_fill (r_fill[r_bucket]),
        .i_row  (ram_rdata),
        .o_row  (new_row),
        .o_upd  (upd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_HASH;
            S_HASH: n_state = S_UPD;
            S_UPD:  if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_total = r_total;
        if (upd.inc) begin
            n_total = r_total + 1'b1;
        end else if (upd.dec && (r_total != '0)) begin
            n_total = r_total - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < bht_pkg::NUM_BUCKETS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_total            <= n_total;
                r_fill[r_bucket]   <= upd.fill;
                r_out_valid        <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= bht_pkg::t_op'(s_axis_tuser);
        end
        if (r_state == S_HASH) begin
            r_bucket <= hash_bucket;
        end
        if (commit) begin
            r_out_status <= upd.status;
            r_out_bucket <= bht_pkg::BUCKET_W'(r_bucket);
            r_out_count  <= bht_pkg::COUNT_W'(n_total);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = bht_pkg::OUT_DATA_W'({r_out_count, r_out_bucket});

endmodule

### tb/bht_result_checker.sv
// bht_result_checker: watches both stream channels of the bucketed hash table,
// predicts each result from its own copy of the buckets and compares in order
// depends on bht_pkg
module bht_result_checker
    import bht_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // key[15:0]
    input  logic                   s_axis_tuser,   // mode[0]
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata,   // bucket_index[3:0], entry_count[10:4]
    input  logic [STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_full_refusals,
    output int                     o_missing_deletes,
    output int                     o_peak_keys
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status              status;
        logic [BUCKET_W-1:0]  bucket;
        logic [COUNT_W-1:0]   count;
    } t_outcome;

    logic [KEY_BITS-1:0] slot_key [NUM_BUCKETS][BUCKET_DEPTH];
    int                  slot_fill [NUM_BUCKETS];
    int                  key_total;
    t_outcome            expected_outcomes [$];
    t_outcome            want;
    t_outcome            got;

    // applies one operation to the shadow buckets and returns its outcome
    function automatic t_outcome apply_operation(t_op op, logic [KEY_FIELD_W-1:0] key_in);
        logic [KEY_BITS-1:0] key;
        int                  b;
        int                  fill;
        int                  pos;
        t_outcome            res;
        key  = key_in[KEY_BITS-1:0];
        b    = key % NUM_BUCKETS;
        fill = slot_fill[b];
        if (op == OP_INSERT) begin
            if (fill >= BUCKET_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // newest key goes to the head, older ones move down
                for (int i = fill; i > 0; i--)
                    slot_key[b][i] = slot_key[b][i-1];
                slot_key[b][0] = key;
                slot_fill[b]   = fill + 1;
                key_total++;
                res.status = ST_INSERTED;
            end
        end else begin
            pos = fill;
            for (int i = 0; i < fill; i++)
                if (pos == fill && slot_key[b][i] == key)
                    pos = i;
            if (pos == fill) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < fill; i++)
                    slot_key[b][i] = slot_key[b][i+1];
                slot_fill[b] = fill - 1;
                if (key_total > 0)
                    key_total--;
                res.status = ST_DELETED;
            end
        end
        res.bucket = BUCKET_W'(b);
        res.count  = COUNT_W'(key_total);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_fill[i])
                slot_fill[i] = 0;
            key_total = 0;
            expected_outcomes.delete();
            o_errors          = 0;
            o_results         = 0;
            o_full_refusals   = 0;
            o_missing_deletes = 0;
            o_peak_keys       = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                got.status = t_status'(m_axis_tuser);
                got.bucket = m_axis_tdata[BUCKET_W-1:0];
                got.count  = m_axis_tdata[BUCKET_W +: COUNT_W];
                if (expected_outcomes.size() == 0) begin
                    o_errors++;
                    $display("%0t ns: result word with nothing expected, got status %0d bucket %0d count %0d",
                             $time, got.status, got.bucket, got.count);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.status != want.status) begin
                        o_errors++;
                        $display("%0t ns: status mismatch, expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.bucket != want.bucket) begin
                        o_errors++;
                        $display("%0t ns: bucket index mismatch, expected %0d got %0d",
                                 $time, want.bucket, got.bucket);
                    end
                    if (got.count != want.count) begin
                        o_errors++;
                        $display("%0t ns: entry count mismatch, expected %0d got %0d",
                                 $time, want.count, got.count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_operation(t_op'(s_axis_tuser), s_axis_tdata);
                expected_outcomes.push_back(want);
                if (want.status == ST_FULL)
                    o_full_refusals++;
                if (want.status == ST_NOT_FOUND)
                    o_missing_deletes++;
                if (key_total > o_peak_keys)
                    o_peak_keys = key_total;
            end
        end
        o_pending = expected_outcomes.size();
    end

endmodule

### tb/bucketed_hash_table_tb.sv
// bucketed_hash_table_tb: drives insert and delete words into the hash table
// with bursty input and a stalling receiver, verdict from bht_result_checker
// depends on bht_pkg, bucketed_hash_table, bht_result_checker
module bucketed_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bht_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_START  = 400;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 12;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // key[15:0]
    logic                  s_axis_tuser;   // mode[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // bucket_index[3:0], entry_count[10:4]
    logic [STATUS_W-1:0]   m_axis_tuser;   // status[1:0]

    int errors;
    int pending;
    int results;
    int full_refusals;
    int missing_deletes;
    int peak_keys;

    int                     burst_left;
    int                     cycle_cnt;
    logic [KEY_FIELD_W-1:0] recent_keys [$];

    bucketed_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bht_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_results         (results),
        .o_full_refusals   (full_refusals),
        .o_missing_deletes (missing_deletes),
        .o_peak_keys       (peak_keys)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver: periodically picks a new random ready style, with one long hold-off
    initial begin
        int rx_cycle;
        int rx_style;
        rx_cycle = 0;
        rx_style = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 48 == 0)
                rx_style = $urandom_range(0, 3);
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                m_axis_tready = 1'b0;
            end else begin
                case (rx_style)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = ($urandom_range(0, 9) != 0);
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // called at a falling edge, returns at a falling edge after acceptance, later if it inserts an idle gap
    task automatic push_word(input t_op op, input logic [KEY_FIELD_W-1:0] key);
        int gap;
        s_axis_tuser  = op;
        s_axis_tdata  = key;
        s_axis_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
        if (op == OP_INSERT) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = 16'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // mix of wide random keys, recently inserted keys and small clustered keys
    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (sel < 70)
            return KEY_FIELD_W'($urandom_range(0, 199));
        else
            return KEY_FIELD_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        t_op                    dir_op  [20];
        logic [KEY_FIELD_W-1:0] dir_key [20];
        int                     phase_len [4];
        int                     phase_ins [4];
        phase_len = '{150, 120, 150, 130};
        phase_ins = '{75, 30, 80, 25};
        // empty buckets, zero and all-ones keys, one bucket filled past its depth
        // with a duplicate, then deletes of the newest copy, the older one and a miss
        dir_op  = '{OP_INSERT, OP_INSERT, OP_DELETE, OP_DELETE, OP_INSERT,
                    OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
                    OP_INSERT, OP_INSERT, OP_INSERT, OP_DELETE, OP_DELETE,
                    OP_DELETE, OP_INSERT, OP_DELETE, OP_DELETE, OP_DELETE};
        dir_key = '{16'd0, 16'd65535, 16'd3, 16'd10, 16'd7,
                    16'd17, 16'd7, 16'd27, 16'd37, 16'd47,
                    16'd57, 16'd65527, 16'd67, 16'd7, 16'd7,
                    16'd7, 16'd97, 16'd65535, 16'd0, 16'd65527};

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        burst_left    = 4;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_op[i])
            push_word(dir_op[i], dir_key[i]);

        // alternating fill-up and drain phases so buckets reach full and empty
        foreach (phase_len[p]) begin
            repeat (phase_len[p]) begin
                if ($urandom_range(0, 99) < phase_ins[p])
                    push_word(OP_INSERT, pick_key());
                else
                    push_word(OP_DELETE, pick_key());
            end
        end
        s_axis_tvalid = 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("checked %0d results: %0d inserts refused on a full bucket, %0d deletes missed",
                 results, full_refusals, missing_deletes);
        $display("peak of %0d stored keys, %0d mismatches", peak_keys, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
